/* sv/exhaustive_balance_search_macros.svh */
// Assertion macros shared by the balance search RTL.
// No dependencies; included inside module bodies.
`ifndef EXHAUSTIVE_BALANCE_SEARCH_MACROS_SVH
`define EXHAUSTIVE_BALANCE_SEARCH_MACROS_SVH

// same-cycle implication
`define EBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ebs_pkg.sv */
// Shared constants and types for the exhaustive balance search.
// No dependencies.
package ebs_pkg;

   localparam int DEF_MAX_GROUPS = 16;
   localparam int DEF_COV_BITS   = 32;
   localparam int DEF_SIZE_BITS  = 10;

   // fixed port field widths
   localparam int REQ_TYPE_W = 2;
   localparam int IDX_W      = 4;
   localparam int COV_W      = 32;
   localparam int GSIZE_W    = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int SCORE_W    = 64;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE_COV  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE_SIZE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_RUN        = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_GROUPS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PARTS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PARTS  = 2'd2;
   localparam logic [CSR_DATA_W-1:0] CSR_RESET_VAL = 5'd2;

   // sign codes, two's complement
   localparam logic [1:0] SIGN_NONE  = 2'b00;
   localparam logic [1:0] SIGN_RIGHT = 2'b01;
   localparam logic [1:0] SIGN_LEFT  = 2'b11;

   localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_SIGNS = 10'b00_0000_0010,
      ST_SCAN  = 10'b00_0000_0100,
      ST_COEF  = 10'b00_0000_1000,
      ST_MUL   = 10'b00_0001_0000,
      ST_DIV   = 10'b00_0010_0000,
      ST_UPD   = 10'b00_0100_0000,
      ST_CMP   = 10'b00_1000_0000,
      ST_NEXT  = 10'b01_0000_0000,
      ST_OUT   = 10'b10_0000_0000
   } state_type;

endpackage

/* sv/exhaustive_balance_search.sv */
// Exhaustive signed-balance search: top level, single module.
// Depends on ebs_pkg and exhaustive_balance_search_macros.svh.
//
//  channel | direction | handshake            | words
//  req_    | in        | req_valid/req_ready  | cov write, size write, run
//  rsp_    | out       | rsp_valid/rsp_ready  | one word per group after a run
//  csr_    | in        | csr_write_enable     | num_groups, min/max part count
//
// A run visits every balance; each balance passes through the matrix scan (one
// cov and size RAM read per cycle), the coefficient multiplier, the serial
// multiply of the three terms (one coefficient bit per cycle up to the top set
// bit of each term) and the bit-serial divider over the NUMW-bit numerator,
// plus the SIGNS, UPD, CMP and NEXT control states. Balances with an empty
// side skip the arithmetic. Reset is synchronous; the RAMs keep their
// contents. Requests are held off from run start until the last response word
// is taken; rsp_ready low simply holds the current word.
module exhaustive_balance_search #(
   parameter int MAX_GROUPS = ebs_pkg::DEF_MAX_GROUPS,
   parameter int COV_BITS   = ebs_pkg::DEF_COV_BITS,
   parameter int SIZE_BITS  = ebs_pkg::DEF_SIZE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [ebs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ebs_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ebs_pkg::REQ_TYPE_W-1:0]        req_type,
   input  logic [ebs_pkg::IDX_W-1:0]             req_row_index,
   input  logic [ebs_pkg::IDX_W-1:0]             req_col_index,
   input  logic signed [ebs_pkg::COV_W-1:0]      req_cov_value,
   input  logic [ebs_pkg::GSIZE_W-1:0]           req_group_size,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ebs_pkg::IDX_W-1:0]             rsp_group_number,
   output logic signed [1:0]                     rsp_sign,
   output logic signed [ebs_pkg::SCORE_W-1:0]    rsp_best_score,
   output logic                                  rsp_status,
   output logic                                  rsp_last
);
   import ebs_pkg::*;

   localparam int CAP  = (MAX_GROUPS < 16) ? MAX_GROUPS : 16;
   localparam int GW   = $clog2(MAX_GROUPS);
   localparam int AW   = $clog2(MAX_GROUPS * MAX_GROUPS);
   localparam int NS   = SIZE_BITS + $clog2(MAX_GROUPS);     // side size sum
   localparam int ACC  = COV_BITS + 2 * $clog2(MAX_GROUPS);  // block sums
   localparam int CW   = 2 * NS + 1;                         // coefficients
   localparam int DW   = 3 * NS + 1;                         // divisor
   localparam int NUMW = ACC + CW + 2;                       // numerator
   localparam int DCW  = $clog2(NUMW + 1);
   localparam int EW   = ((NUMW > SCORE_W) ? NUMW : SCORE_W) + 1;

   // ---------------- registers ----------------
   state_type                  state_ff, state_in;
   logic [CSR_DATA_W-1:0]      num_groups_ff, min_pc_ff, max_pc_ff;
   logic [GW-1:0]              gm1_ff, gm1_in;          // groups in use - 1
   logic                       bad_ff, bad_in;
   logic [CSR_DATA_W-1:0]      k_ff, k_in;              // part count
   logic [MAX_GROUPS-1:0]      pc_ff, pc_in;            // pattern counter
   logic [GW-1:0]              sup_ff [MAX_GROUPS];
   logic [GW-1:0]              sup_in [MAX_GROUPS];
   logic [1:0]                 trial_ff [MAX_GROUPS];
   logic [1:0]                 trial_in [MAX_GROUPS];
   logic [1:0]                 best_signs_ff [MAX_GROUPS];
   logic [1:0]                 best_signs_in [MAX_GROUPS];
   logic signed [SCORE_W-1:0]  best_ff, best_in;
   logic                       found_ff, found_in;
   // matrix scan
   logic [GW-1:0]              ri_ff, ri_in, ci_ff, ci_in;
   logic                       iss_done_ff, iss_done_in;
   logic                       rd_vld_ff;
   logic [GW-1:0]              rd_row_ff, rd_col_ff;
   logic signed [COV_BITS-1:0] mem_q_ff;
   logic [NS-1:0]              nl_ff, nl_in, nr_ff, nr_in;
   logic signed [ACC-1:0]      sll_ff, sll_in, srr_ff, srr_in, slr_ff, slr_in;
   // coefficients and serial multiply
   logic [1:0]                 cstep_ff, cstep_in;
   logic [2*NS-1:0]            c_ll_ff, c_ll_in, c_rr_ff, c_rr_in, c_lr_ff, c_lr_in;
   logic [NS:0]                nsum_ff, nsum_in;
   logic [DW-1:0]              d_ff, d_in;
   logic [1:0]                 tm_ff, tm_in;
   logic [NUMW-1:0]            mcand_ff, mcand_in, num_ff, num_in;
   logic [CW-1:0]              coef_ff, coef_in;
   // divider
   logic                       neg_ff, neg_in;
   logic [NUMW-1:0]            dq_ff, dq_in;
   logic [DW-1:0]              rem_ff, rem_in;
   logic [DCW-1:0]             dcnt_ff, dcnt_in;
   logic signed [SCORE_W-1:0]  score_ff, score_in;
   // response
   logic [GW-1:0]              oi_ff, oi_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // ---------------- memories ----------------
   logic [COV_BITS-1:0]  cov_mem [MAX_GROUPS * MAX_GROUPS];
   logic [SIZE_BITS-1:0] size_mem [MAX_GROUPS];
   logic [SIZE_BITS-1:0] size_q_ff;

   logic          req_acc, cov_we, size_we, rd_en;
   logic [AW-1:0] cov_waddr, rd_addr;

   assign req_acc   = req_valid && req_ready;
   assign cov_we    = req_acc && (req_type == REQ_WRITE_COV)
                      && (int'(req_row_index) < MAX_GROUPS)
                      && (int'(req_col_index) < MAX_GROUPS);
   assign size_we   = req_acc && (req_type == REQ_WRITE_SIZE)
                      && (int'(req_row_index) < MAX_GROUPS);
   assign cov_waddr = AW'(AW'(req_row_index) * AW'(MAX_GROUPS) + AW'(req_col_index));

   always_ff @(posedge clock) begin
      if (cov_we) begin
         cov_mem[cov_waddr] <= COV_BITS'(req_cov_value);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= cov_mem[rd_addr];
      end
   end

   // sizes are read alongside the matrix row, same latency
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[GW'(req_row_index)] <= SIZE_BITS'(req_group_size);
      end
      if (rd_en) begin
         size_q_ff <= size_mem[ri_ff];
      end
   end

   // ---------------- helpers ----------------
   logic [MAX_GROUPS-1:0] gray, pat_last;
   logic                  adv_ok;
   logic [GW-1:0]         adv_pos;
   logic [5:0]            g6;
   logic [GW:0]           g_run;
   logic                  bad_run;
   logic [DW:0]           div_trial;
   logic                  div_ge;
   logic [2*NS-1:0]       mul_a;
   logic [NS:0]           mul_b;
   logic [DW-1:0]         mul_p;
   logic [EW-1:0]         q_ext;
   logic signed [SCORE_W-1:0] sat;
   logic [1:0]            s_row, s_col;
   logic signed [ACC-1:0] cov_ext;

   assign gray     = pc_ff ^ (pc_ff >> 1);
   assign pat_last = (MAX_GROUPS'(1) << (k_ff - 5'd1)) - MAX_GROUPS'(1);
   assign g6       = 6'(gm1_ff) + 6'd1;

   // rightmost support slot that can still move up
   always_comb begin
      adv_ok  = 1'b0;
      adv_pos = '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
         if ((i < int'(k_ff)) &&
             (6'(sup_ff[i]) < 6'(g6 - 6'(k_ff) + 6'(i)))) begin
            adv_ok  = 1'b1;
            adv_pos = GW'(i);
         end
      end
   end

   // clamp and check settings at run start
   always_comb begin
      if (num_groups_ff < 5'd2) begin
         g_run = (GW+1)'(2);
      end else if (int'(num_groups_ff) > CAP) begin
         g_run = (GW+1)'(CAP);
      end else begin
         g_run = (GW+1)'(num_groups_ff);
      end
      bad_run = (num_groups_ff < 5'd2) || (int'(num_groups_ff) > CAP) ||
                (min_pc_ff < 5'd2) || (max_pc_ff < min_pc_ff) ||
                (max_pc_ff > num_groups_ff);
   end

   assign div_trial = {rem_ff, dq_ff[NUMW-1]};
   assign div_ge    = div_trial >= {1'b0, d_ff};

   always_comb begin
      case (cstep_ff)
         2'd0:    begin mul_a = (2*NS)'(nr_ff);  mul_b = (NS+1)'(nr_ff); end
         2'd1:    begin mul_a = (2*NS)'(nl_ff);  mul_b = (NS+1)'(nl_ff); end
         2'd2:    begin mul_a = (2*NS)'(nl_ff);  mul_b = (NS+1)'(nr_ff); end
         default: begin mul_a = c_lr_ff;         mul_b = nsum_ff;        end
      endcase
      mul_p = DW'(mul_a) * DW'(mul_b);
   end

   // truncated quotient to saturated 64-bit score
   always_comb begin
      q_ext = EW'(dq_ff);
      if (!neg_ff) begin
         sat = (q_ext > EW'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(dq_ff);
      end else begin
         sat = (q_ext >= EW'(SCORE_MIN)) ? SCORE_MIN : -SCORE_W'(dq_ff);
      end
   end

   assign s_row   = trial_ff[rd_row_ff];
   assign s_col   = trial_ff[rd_col_ff];
   assign cov_ext = ACC'(mem_q_ff);

   // ---------------- next state ----------------
   always_comb begin
      state_in     = state_ff;
      gm1_in       = gm1_ff;
      bad_in       = bad_ff;
      k_in         = k_ff;
      pc_in        = pc_ff;
      sup_in       = sup_ff;
      trial_in     = trial_ff;
      best_signs_in = best_signs_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      ri_in        = ri_ff;
      ci_in        = ci_ff;
      iss_done_in  = iss_done_ff;
      nl_in        = nl_ff;
      nr_in        = nr_ff;
      sll_in       = sll_ff;
      srr_in       = srr_ff;
      slr_in       = slr_ff;
      cstep_in     = cstep_ff;
      c_ll_in      = c_ll_ff;
      c_rr_in      = c_rr_ff;
      c_lr_in      = c_lr_ff;
      nsum_in      = nsum_ff;
      d_in         = d_ff;
      tm_in        = tm_ff;
      mcand_in     = mcand_ff;
      coef_in      = coef_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      score_in     = score_ff;
      oi_in        = oi_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(AW'(ri_ff) * AW'(MAX_GROUPS) + AW'(ci_ff));

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_type == REQ_RUN)) begin
               gm1_in   = GW'(g_run - (GW+1)'(1));
               bad_in   = bad_run;
               best_in  = SCORE_MIN;
               found_in = 1'b0;
               for (int q = 0; q < MAX_GROUPS; q++) begin
                  best_signs_in[q] = SIGN_NONE;
                  sup_in[q]        = GW'(q);
               end
               k_in  = min_pc_ff;
               pc_in = MAX_GROUPS'(1);
               oi_in = '0;
               if (bad_run) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end else begin
                  state_in = ST_SIGNS;
               end
            end
         end

         ST_SIGNS: begin
            // first support member always left, the rest follow the Gray code
            for (int q = 0; q < MAX_GROUPS; q++) begin
               trial_in[q] = SIGN_NONE;
            end
            for (int p = 0; p < MAX_GROUPS; p++) begin
               if (p < int'(k_ff)) begin
                  if (p == 0) begin
                     trial_in[sup_ff[p]] = SIGN_LEFT;
                  end else begin
                     trial_in[sup_ff[p]] = gray[(p > 0) ? p - 1 : 0] ? SIGN_RIGHT
                                                                     : SIGN_LEFT;
                  end
               end
            end
            ri_in       = '0;
            ci_in       = '0;
            iss_done_in = 1'b0;
            nl_in       = '0;
            nr_in       = '0;
            sll_in      = '0;
            srr_in      = '0;
            slr_in      = '0;
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            if (!iss_done_ff) begin
               rd_en = 1'b1;
               if (ci_ff == gm1_ff) begin
                  ci_in = '0;
                  if (ri_ff == gm1_ff) begin
                     iss_done_in = 1'b1;
                  end else begin
                     ri_in = ri_ff + GW'(1);
                  end
               end else begin
                  ci_in = ci_ff + GW'(1);
               end
            end
            if (rd_vld_ff) begin
               // side sizes once per row, on the first column
               if (rd_col_ff == '0) begin
                  if (s_row == SIGN_LEFT) begin
                     nl_in = nl_ff + NS'(size_q_ff);
                  end else if (s_row == SIGN_RIGHT) begin
                     nr_in = nr_ff + NS'(size_q_ff);
                  end
               end
               if ((s_row == SIGN_LEFT) && (s_col == SIGN_LEFT)) begin
                  sll_in = sll_ff + cov_ext;
               end else if ((s_row == SIGN_RIGHT) && (s_col == SIGN_RIGHT)) begin
                  srr_in = srr_ff + cov_ext;
               end else if ((s_row == SIGN_RIGHT) && (s_col == SIGN_LEFT)) begin
                  slr_in = slr_ff + cov_ext;
               end
            end else if (iss_done_ff) begin
               cstep_in = 2'd0;
               state_in = ST_COEF;
            end
         end

         ST_COEF: begin
            cstep_in = cstep_ff + 2'd1;
            case (cstep_ff)
               2'd0: begin
                  if ((nl_ff == '0) || (nr_ff == '0)) begin
                     state_in = ST_NEXT;       // empty side: not a balance
                  end
                  c_ll_in = (2*NS)'(mul_p);
                  nsum_in = (NS+1)'(nl_ff) + (NS+1)'(nr_ff);
               end
               2'd1: c_rr_in = (2*NS)'(mul_p);
               2'd2: c_lr_in = (2*NS)'(mul_p);
               default: begin
                  d_in     = mul_p;
                  tm_in    = 2'd0;
                  mcand_in = NUMW'(sll_ff);
                  coef_in  = CW'(c_ll_ff);
                  num_in   = '0;
                  state_in = ST_MUL;
               end
            endcase
         end

         ST_MUL: begin
            if (coef_ff != '0) begin
               if (coef_ff[0]) begin
                  num_in = (tm_ff == 2'd2) ? num_ff - mcand_ff : num_ff + mcand_ff;
               end
               mcand_in = mcand_ff << 1;
               coef_in  = coef_ff >> 1;
            end else begin
               case (tm_ff)
                  2'd0: begin
                     tm_in    = 2'd1;
                     mcand_in = NUMW'(srr_ff);
                     coef_in  = CW'(c_rr_ff);
                  end
                  2'd1: begin
                     tm_in    = 2'd2;
                     mcand_in = NUMW'(slr_ff);
                     coef_in  = {c_lr_ff, 1'b0};
                  end
                  default: begin
                     neg_in   = num_ff[NUMW-1];
                     dq_in    = num_ff[NUMW-1] ? -num_ff : num_ff;
                     rem_in   = '0;
                     dcnt_in  = DCW'(NUMW);
                     state_in = ST_DIV;
                  end
               endcase
            end
         end

         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in  = div_ge ? DW'(div_trial - {1'b0, d_ff}) : DW'(div_trial);
            dq_in   = {dq_ff[NUMW-2:0], div_ge};
            dcnt_in = dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) begin
               state_in = ST_UPD;
            end
         end

         ST_UPD: begin
            score_in = sat;
            state_in = ST_CMP;
         end

         ST_CMP: begin
            if (!found_ff || (score_ff > best_ff)) begin
               found_in      = 1'b1;
               best_in       = score_ff;
               best_signs_in = trial_ff;
            end
            state_in = ST_NEXT;
         end

         ST_NEXT: begin
            state_in = ST_SIGNS;
            if (pc_ff != pat_last) begin
               pc_in = pc_ff + MAX_GROUPS'(1);
            end else if (adv_ok) begin
               pc_in = MAX_GROUPS'(1);
               for (int m = 0; m < MAX_GROUPS; m++) begin
                  if (GW'(m) == adv_pos) begin
                     sup_in[m] = sup_ff[m] + GW'(1);
                  end else if (GW'(m) > adv_pos) begin
                     sup_in[m] = GW'(int'(sup_ff[adv_pos]) + 1 + m - int'(adv_pos));
                  end
               end
            end else if (k_ff < max_pc_ff) begin
               pc_in = MAX_GROUPS'(1);
               k_in  = k_ff + 5'd1;
               for (int m = 0; m < MAX_GROUPS; m++) begin
                  sup_in[m] = GW'(m);
               end
            end else begin
               oi_in        = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end

         ST_OUT: begin
            if (rsp_ready) begin
               if (oi_ff == gm1_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  oi_in = oi_ff + GW'(1);
               end
            end
         end

         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_groups_ff <= CSR_RESET_VAL;
         min_pc_ff     <= CSR_RESET_VAL;
         max_pc_ff     <= CSR_RESET_VAL;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         best_ff       <= SCORE_MIN;
         pc_ff         <= '0;
         for (int q = 0; q < MAX_GROUPS; q++) begin
            trial_ff[q]      <= SIGN_NONE;
            best_signs_ff[q] <= SIGN_NONE;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_vld_ff     <= rd_en;
         found_ff      <= found_in;
         best_ff       <= best_in;
         pc_ff         <= pc_in;
         trial_ff      <= trial_in;
         best_signs_ff <= best_signs_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_NUM_GROUPS: num_groups_ff <= csr_write_data;
               CSR_MIN_PARTS:  min_pc_ff     <= csr_write_data;
               CSR_MAX_PARTS:  max_pc_ff     <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      gm1_ff      <= gm1_in;
      bad_ff      <= bad_in;
      k_ff        <= k_in;
      sup_ff      <= sup_in;
      ri_ff       <= ri_in;
      ci_ff       <= ci_in;
      iss_done_ff <= iss_done_in;
      rd_row_ff   <= ri_ff;
      rd_col_ff   <= ci_ff;
      nl_ff       <= nl_in;
      nr_ff       <= nr_in;
      sll_ff      <= sll_in;
      srr_ff      <= srr_in;
      slr_ff      <= slr_in;
      cstep_ff    <= cstep_in;
      c_ll_ff     <= c_ll_in;
      c_rr_ff     <= c_rr_in;
      c_lr_ff     <= c_lr_in;
      nsum_ff     <= nsum_in;
      d_ff        <= d_in;
      tm_ff       <= tm_in;
      mcand_ff    <= mcand_in;
      coef_ff     <= coef_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      score_ff    <= score_in;
      oi_ff       <= oi_in;
   end

   // ---------------- ports ----------------
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_group_number = IDX_W'(oi_ff);
   assign rsp_sign         = best_signs_ff[oi_ff];
   assign rsp_best_score   = best_ff;
   assign rsp_status       = bad_ff;
   assign rsp_last         = (oi_ff == gm1_ff);

   // ---------------- assertions ----------------
   `include "exhaustive_balance_search_macros.svh"

   logic rsp_done, div_last;
   assign rsp_done = rsp_valid && rsp_ready && rsp_last;
   assign div_last = (state_ff == ST_DIV) && (dcnt_ff == DCW'(1));

   `EBS_ASSERT_NOW(a_rsp_only_in_out, clock, reset, rsp_valid, state_ff == ST_OUT, "rsp outside out")
   `EBS_ASSERT_NOW(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready, "req ready during rsp")
   `EBS_ASSERT_NEXT(a_div_ends, clock, reset, div_last, state_ff == ST_UPD, "divide overran")
   `EBS_ASSERT_NEXT(a_last_to_idle, clock, reset, rsp_done, req_ready && !rsp_valid, "no idle after last")

endmodule
